// ===== rtl/clws_pkg.sv =====
// Shared types, constants and tables of the character LCD write sequencer.
package clws_pkg;

    localparam int CFG_W = 26;

    // Configuration register indexes.
    localparam logic [1:0] CFG_BUS_MODE    = 2'd0;
    localparam logic [1:0] CFG_ENABLE_HIGH = 2'd1;
    localparam logic [1:0] CFG_AFTER_PULSE = 2'd2;
    localparam logic [1:0] CFG_WAKEUP      = 2'd3;

    // Request codes.
    localparam logic [2:0] OP_CHAR    = 3'd0;
    localparam logic [2:0] OP_COMMAND = 3'd1;
    localparam logic [2:0] OP_NUMBER  = 3'd2;
    localparam logic [2:0] OP_GOTO    = 3'd3;
    localparam logic [2:0] OP_INIT    = 3'd4;

    localparam logic       RS_COMMAND = 1'b0;
    localparam logic       RS_DATA    = 1'b1;

    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;
    localparam logic [7:0] ROW0_BASE   = 8'h80;
    localparam logic [7:0] ROW1_BASE   = 8'hC0;
    localparam logic [7:0] MAX_COLUMN  = 8'd15;

    // floor(x / 10) == (x * RECIP10) >> RECIP10_SHIFT for every 32-bit x.
    localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
    localparam int          RECIP10_SHIFT = 35;

    localparam logic [2:0] INIT4_LEN = 3'd6;
    localparam logic [2:0] INIT8_LEN = 3'd4;

    typedef struct packed {
        logic              bus_mode;
        logic [CFG_W-1:0]  enable_high;
        logic [CFG_W-1:0]  after_pulse;
        logic [CFG_W-1:0]  wakeup;
    } t_cfg;

    // One byte queued for the bus side.
    typedef struct packed {
        logic       rs;
        logic [7:0] value;
        logic       last;
        logic       wake;   // power-up wait comes before this byte
    } t_xfer;

    typedef enum logic [2:0] {
        F_IDLE,
        F_SINGLE,
        F_SIGN,
        F_DIV,
        F_REM,
        F_DIGITS,
        F_INIT
    } t_fstate;

    typedef enum logic [2:0] {
        B_IDLE,
        B_WAKE,
        B_HIGH,
        B_GAP,
        B_OUT
    } t_bstate;

    function automatic logic [7:0] init_byte(input logic four_bit, input logic [2:0] idx);
        logic [7:0] b;
        b = 8'h00;
        if (four_bit) begin
            case (idx)
                3'd0:    b = 8'h33;
                3'd1:    b = 8'h32;
                3'd2:    b = 8'h28;
                3'd3:    b = 8'h01;
                3'd4:    b = 8'h02;
                3'd5:    b = 8'h0C;
                default: b = 8'h00;
            endcase
        end else begin
            case (idx)
                3'd0:    b = 8'h38;
                3'd1:    b = 8'h01;
                3'd2:    b = 8'h02;
                3'd3:    b = 8'h0C;
                default: b = 8'h00;
            endcase
        end
        return b;
    endfunction

endpackage

// ===== rtl/clws_front.sv =====
// Request decoder: classifies requests and turns them into a series of bus bytes.
module clws_front import clws_pkg::*; #(
    parameter int MAX_DIGITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_operation,
    input  logic [7:0]  i_byte_value,
    input  logic [31:0] i_number,
    input  logic [7:0]  i_row,
    input  logic [7:0]  i_column,
    input  logic        i_bus_mode,
    output logic        o_push,
    output t_xfer       o_xfer,
    input  logic        i_full
);

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(MAX_DIGITS - 1);

    t_fstate r_state, n_state;

    logic [7:0]       r_byte;
    logic             r_rs;
    logic [31:0]      r_mag;
    logic [63:0]      r_prod;
    logic [3:0]       r_dig [MAX_DIGITS];
    logic [IDX_W-1:0] r_n;
    logic [IDX_W-1:0] r_rd;
    logic [2:0]       r_idx;

    logic             w_accept;
    logic             w_want;
    logic [28:0]      w_quot;
    logic [31:0]      w_diff;
    logic             w_conv_done;
    logic [2:0]       w_init_len;
    logic [3:0]       w_col;
    logic [31:0]      w_mag_in;

    assign w_accept    = i_valid && o_ready;
    assign w_quot      = r_prod[63:RECIP10_SHIFT];
    assign w_diff      = r_mag - {w_quot, 3'b000} - {2'b00, w_quot, 1'b0};
    assign w_conv_done = (w_quot == 29'd0) || (r_n == TOP_IDX);
    assign w_init_len  = i_bus_mode ? INIT4_LEN : INIT8_LEN;
    assign w_col       = (i_column > MAX_COLUMN) ? 4'd0 : i_column[3:0];
    assign w_mag_in    = i_number[31] ? (~i_number + 32'd1) : i_number;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    unique case (i_operation) inside
                        OP_CHAR, OP_COMMAND, OP_GOTO: n_state = F_SINGLE;
                        OP_NUMBER: begin
                            if (i_number == 32'd0) begin
                                n_state = F_SINGLE;
                            end else if (i_number[31]) begin
                                n_state = F_SIGN;
                            end else begin
                                n_state = F_DIV;
                            end
                        end
                        OP_INIT: n_state = F_INIT;
                        default: n_state = F_IDLE;
                    endcase
                end
            end
            F_SINGLE: if (!i_full) n_state = F_IDLE;
            F_SIGN:   if (!i_full) n_state = F_DIV;
            F_DIV:    n_state = F_REM;
            F_REM:    n_state = w_conv_done ? F_DIGITS : F_DIV;
            F_DIGITS: if (!i_full && r_rd == '0) n_state = F_IDLE;
            F_INIT:   if (!i_full && r_idx == w_init_len - 3'd1) n_state = F_IDLE;
            default:  n_state = F_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_ready      = 1'b0;
        w_want       = 1'b0;
        o_xfer.rs    = RS_COMMAND;
        o_xfer.value = 8'h00;
        o_xfer.last  = 1'b0;
        o_xfer.wake  = 1'b0;
        unique case (r_state)
            F_IDLE: o_ready = 1'b1;
            F_SINGLE: begin
                w_want       = 1'b1;
                o_xfer.rs    = r_rs;
                o_xfer.value = r_byte;
                o_xfer.last  = 1'b1;
            end
            F_SIGN: begin
                w_want       = 1'b1;
                o_xfer.rs    = RS_DATA;
                o_xfer.value = ASCII_MINUS;
            end
            F_DIGITS: begin
                w_want       = 1'b1;
                o_xfer.rs    = RS_DATA;
                o_xfer.value = ASCII_ZERO + {4'd0, r_dig[r_rd]};
                o_xfer.last  = (r_rd == '0);
            end
            F_INIT: begin
                w_want       = 1'b1;
                o_xfer.value = init_byte(i_bus_mode, r_idx);
                o_xfer.last  = (r_idx == w_init_len - 3'd1);
                o_xfer.wake  = (r_idx == 3'd0);
            end
            default: ;
        endcase
        o_push = w_want && !i_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_n   <= '0;
            r_idx <= 3'd0;
            r_mag <= w_mag_in;
            case (i_operation)
                OP_CHAR: begin
                    r_rs   <= RS_DATA;
                    r_byte <= i_byte_value;
                end
                OP_GOTO: begin
                    r_rs   <= RS_COMMAND;
                    r_byte <= ((i_row == 8'd1) ? ROW1_BASE : ROW0_BASE) + {4'd0, w_col};
                end
                OP_NUMBER: begin
                    r_rs   <= RS_DATA;
                    r_byte <= ASCII_ZERO;
                end
                default: begin
                    r_rs   <= RS_COMMAND;
                    r_byte <= i_byte_value;
                end
            endcase
        end
        if (r_state == F_DIV) begin
            r_prod <= r_mag * RECIP10;
        end
        if (r_state == F_REM) begin
            r_dig[r_n] <= w_diff[3:0];
            r_mag      <= {3'd0, w_quot};
            r_rd       <= r_n;
            r_n        <= r_n + IDX_W'(1);
        end
        if (r_state == F_DIGITS && !i_full) begin
            r_rd <= r_rd - IDX_W'(1);
        end
        if (r_state == F_INIT && !i_full) begin
            r_idx <= r_idx + 3'd1;
        end
    end

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == F_REM) |-> (w_diff < 32'd10))
        else $error("decimal remainder out of range");

endmodule

// ===== rtl/clws_queue.sv =====
// Short queue of bus bytes between the request decoder and the bus sequencer.
module clws_queue import clws_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_xfer i_xfer,
    output logic  o_full,
    input  logic  i_pop,
    output t_xfer o_head,
    output logic  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_xfer            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic             w_wr_en, w_rd_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr_en = i_push && !o_full;
    assign w_rd_en = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr] <= i_xfer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_wr_en) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (w_rd_en) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (w_wr_en && !w_rd_en) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_rd_en && !w_wr_en) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue fill count above depth");

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("byte pushed into a full queue");

endmodule

// ===== rtl/clws_back.sv =====
// Bus sequencer: sends bytes as transfers, paced by wake-up, enable and gap counts.
module clws_back import clws_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_empty,
    input  t_xfer      i_head,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_rs,
    output logic [7:0] o_bus_value,
    output logic       o_last
);

    t_bstate          r_state, n_state;
    t_xfer            r_cur;
    logic             r_half;
    logic [CFG_W-1:0] r_cnt;
    logic             r_o_valid;
    logic             r_o_rs;
    logic [7:0]       r_o_value;
    logic             r_o_last;

    logic             w_load;
    logic             w_wait_wake;
    logic             w_cnt_zero;

    assign w_wait_wake = i_head.wake && (i_cfg.wakeup != '0);
    assign w_cnt_zero  = (r_cnt == '0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: if (!i_empty) n_state = w_wait_wake ? B_WAKE : B_HIGH;
            B_WAKE: if (w_cnt_zero) n_state = B_HIGH;
            B_HIGH: if (w_cnt_zero) n_state = B_GAP;
            B_GAP:  if (w_cnt_zero) n_state = B_OUT;
            B_OUT: begin
                if (!r_o_valid || i_ready) begin
                    n_state = (i_cfg.bus_mode && !r_half) ? B_HIGH : B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop  = 1'b0;
        w_load = 1'b0;
        unique case (r_state)
            B_IDLE:  o_pop  = !i_empty;
            B_OUT:   w_load = !r_o_valid || i_ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur  <= i_head;
            r_half <= 1'b0;
            r_cnt  <= w_wait_wake ? i_cfg.wakeup - CFG_W'(1) : i_cfg.enable_high - CFG_W'(1);
        end
        unique case (r_state)
            B_WAKE: r_cnt <= w_cnt_zero ? i_cfg.enable_high - CFG_W'(1) : r_cnt - CFG_W'(1);
            B_HIGH: r_cnt <= w_cnt_zero ? i_cfg.after_pulse - CFG_W'(1) : r_cnt - CFG_W'(1);
            B_GAP:  if (!w_cnt_zero) r_cnt <= r_cnt - CFG_W'(1);
            default: ;
        endcase
        if (w_load) begin
            r_o_rs <= r_cur.rs;
            if (i_cfg.bus_mode) begin
                // High nibble goes first; both ride in the low four bits.
                r_o_value <= r_half ? {4'd0, r_cur.value[3:0]} : {4'd0, r_cur.value[7:4]};
                r_o_last  <= r_cur.last && r_half;
                r_half    <= !r_half;
                r_cnt     <= i_cfg.enable_high - CFG_W'(1);
            end else begin
                r_o_value <= r_cur.value;
                r_o_last  <= r_cur.last;
            end
        end
    end

    assign o_valid     = r_o_valid;
    assign o_rs        = r_o_rs;
    assign o_bus_value = r_o_value;
    assign o_last      = r_o_last;

endmodule

// ===== rtl/char_lcd_write_sequencer_core.sv =====
// Top level of the character LCD write sequencer: configuration registers and wiring.
//
// Each request (character, command, signed number, go to row and column, or
// initialize) becomes one or more bus transfers on the output stream, each a
// register-select bit and a byte, or two nibble items (high nibble first) in
// four-bit mode; tlast marks the final transfer of a request. Every transfer
// is paced by the bus sequencer: it waits out the enable-high count and then
// the after-pulse count before it is offered, and the first transfer of an
// initialization first waits out the wakeup count. A number is converted
// one decimal digit at a time by a reciprocal multiply before its characters
// are queued; the decoder and the sequencer are joined by a four-entry
// queue, so the next request is taken as soon as the decoder has queued the
// last byte of the current one.
module char_lcd_write_sequencer_core import clws_pkg::*; #(
    parameter int MAX_DIGITS = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_addr,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // [7:0] byte_value, [39:8] number, [47:40] row, [55:48] column
    input  logic [55:0]      s_axis_tdata,
    // [2:0] operation
    input  logic [2:0]       s_axis_tuser,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // [0] register_select, [8:1] bus_value, [15:9] zero
    output logic [15:0]      m_axis_tdata,
    output logic             m_axis_tlast
);

    t_cfg       r_cfg;
    logic       w_push, w_full, w_pop, w_empty;
    t_xfer      w_in_xfer, w_head;
    logic       w_rs;
    logic [7:0] w_bus_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bus_mode    <= 1'b1;
            r_cfg.enable_high <= CFG_W'(50000);
            r_cfg.after_pulse <= CFG_W'(150000);
            r_cfg.wakeup      <= CFG_W'(50000000);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_BUS_MODE:    r_cfg.bus_mode    <= i_cfg_wdata[0];
                CFG_ENABLE_HIGH: r_cfg.enable_high <= i_cfg_wdata;
                CFG_AFTER_PULSE: r_cfg.after_pulse <= i_cfg_wdata;
                CFG_WAKEUP:      r_cfg.wakeup      <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    clws_front #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_operation  (s_axis_tuser),
        .i_byte_value (s_axis_tdata[7:0]),
        .i_number     (s_axis_tdata[39:8]),
        .i_row        (s_axis_tdata[47:40]),
        .i_column     (s_axis_tdata[55:48]),
        .i_bus_mode   (r_cfg.bus_mode),
        .o_push       (w_push),
        .o_xfer       (w_in_xfer),
        .i_full       (w_full)
    );

    clws_queue #(
        .DEPTH (4)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_xfer  (w_in_xfer),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty)
    );

    clws_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_empty     (w_empty),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_rs        (w_rs),
        .o_bus_value (w_bus_value),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, w_bus_value, w_rs};

endmodule

// ===== sim/tb_char_lcd_write_sequencer_core.sv =====
// Self-checking testbench for the character LCD write sequencer core.
module tb_char_lcd_write_sequencer_core;
    timeunit 1ns;
    timeprecision 1ps;
    import clws_pkg::*;

    localparam int NUM_DIGITS  = 10;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int MAX_REPORTS = 10;

    // Request codes that the block must ignore.
    localparam logic [2:0] OP_SPARE5 = 3'd5;
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;

    localparam logic [7:0] INIT_FOUR [6] = '{8'h33, 8'h32, 8'h28, 8'h01, 8'h02, 8'h0C};
    localparam logic [7:0] INIT_EIGHT[4] = '{8'h38, 8'h01, 8'h02, 8'h0C};

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  byte_v;
        logic [31:0] number;
        logic [7:0]  row;
        logic [7:0]  column;
    } t_request;

    typedef struct packed {
        logic       rs;
        logic [7:0] value;
        logic       last;
    } t_bus_xfer;

    // A register write keeps its index in the low bits of op and its value in number.
    // Typed transfers are {rs, value} pairs, the first one in the top bits.
    typedef struct packed {
        logic        is_cfg;
        t_request    req;
        logic        typed;
        logic [2:0]  n_typed;
        logic [35:0] typed_xfers;
    } t_stim_row;

    localparam t_stim_row DIRECTED_ROWS [24] = '{
        '{1'b0, '{OP_CHAR, 8'h41, 32'd0, 8'd0, 8'd0}, 1'b1, 3'd2,
          {{RS_DATA, 8'h04}, {RS_DATA, 8'h01}, 18'd0}},
        '{1'b0, '{OP_CHAR, 8'h00, 32'd0, 8'd0, 8'd0}, 1'b1, 3'd2,
          {{RS_DATA, 8'h00}, {RS_DATA, 8'h00}, 18'd0}},
        '{1'b0, '{OP_CHAR, 8'hFF, 32'd0, 8'd0, 8'd0}, 1'b1, 3'd2,
          {{RS_DATA, 8'h0F}, {RS_DATA, 8'h0F}, 18'd0}},
        '{1'b0, '{OP_COMMAND, 8'h01, 32'd0, 8'd0, 8'd0}, 1'b1, 3'd2,
          {{RS_COMMAND, 8'h00}, {RS_COMMAND, 8'h01}, 18'd0}},
        '{1'b0, '{OP_GOTO, 8'h00, 32'd0, 8'd1, 8'd15}, 1'b1, 3'd2,
          {{RS_COMMAND, 8'h0C}, {RS_COMMAND, 8'h0F}, 18'd0}},
        '{1'b0, '{OP_GOTO, 8'h00, 32'd0, 8'd0, 8'd0}, 1'b1, 3'd2,
          {{RS_COMMAND, 8'h08}, {RS_COMMAND, 8'h00}, 18'd0}},
        '{1'b0, '{OP_GOTO, 8'h00, 32'd0, 8'd2, 8'd16}, 1'b1, 3'd2,
          {{RS_COMMAND, 8'h08}, {RS_COMMAND, 8'h00}, 18'd0}},
        '{1'b0, '{OP_GOTO, 8'h00, 32'd0, 8'd255, 8'd255}, 1'b1, 3'd2,
          {{RS_COMMAND, 8'h08}, {RS_COMMAND, 8'h00}, 18'd0}},
        '{1'b0, '{OP_NUMBER, 8'h00, 32'd0, 8'd0, 8'd0}, 1'b1, 3'd2,
          {{RS_DATA, 8'h03}, {RS_DATA, 8'h00}, 18'd0}},
        '{1'b0, '{OP_NUMBER, 8'h00, 32'hFFFF_FFFF, 8'd0, 8'd0}, 1'b1, 3'd4,
          {{RS_DATA, 8'h02}, {RS_DATA, 8'h0D}, {RS_DATA, 8'h03}, {RS_DATA, 8'h01}}},
        '{1'b0, '{OP_NUMBER, 8'h00, 32'h8000_0000, 8'd0, 8'd0}, 1'b0, 3'd0, 36'd0},
        '{1'b0, '{OP_NUMBER, 8'h00, 32'h7FFF_FFFF, 8'd0, 8'd0}, 1'b0, 3'd0, 36'd0},
        '{1'b0, '{OP_INIT, 8'h00, 32'd0, 8'd0, 8'd0}, 1'b0, 3'd0, 36'd0},
        '{1'b0, '{OP_SPARE5, 8'hFF, 32'hFFFF_FFFF, 8'd255, 8'd255}, 1'b1, 3'd0, 36'd0},
        '{1'b0, '{OP_SPARE6, 8'h41, 32'd0, 8'd1, 8'd3}, 1'b1, 3'd0, 36'd0},
        '{1'b0, '{OP_SPARE7, 8'h00, 32'd7, 8'd0, 8'd0}, 1'b1, 3'd0, 36'd0},
        '{1'b1, '{{1'b0, CFG_BUS_MODE}, 8'h00, 32'h03FF_FFFE, 8'd0, 8'd0}, 1'b0, 3'd0,
          36'd0},
        '{1'b0, '{OP_CHAR, 8'h5A, 32'd0, 8'd0, 8'd0}, 1'b1, 3'd1,
          {{RS_DATA, 8'h5A}, 27'd0}},
        '{1'b0, '{OP_COMMAND, 8'hFF, 32'd0, 8'd0, 8'd0}, 1'b1, 3'd1,
          {{RS_COMMAND, 8'hFF}, 27'd0}},
        '{1'b0, '{OP_NUMBER, 8'h00, 32'hFFFF_FFFF, 8'd0, 8'd0}, 1'b1, 3'd2,
          {{RS_DATA, 8'h2D}, {RS_DATA, 8'h31}, 18'd0}},
        '{1'b0, '{OP_NUMBER, 8'h00, 32'd1000000000, 8'd0, 8'd0}, 1'b0, 3'd0, 36'd0},
        '{1'b0, '{OP_GOTO, 8'h00, 32'd0, 8'd1, 8'd3}, 1'b1, 3'd1,
          {{RS_COMMAND, 8'hC3}, 27'd0}},
        '{1'b0, '{OP_INIT, 8'h00, 32'd0, 8'd0, 8'd0}, 1'b0, 3'd0, 36'd0},
        '{1'b0, '{OP_NUMBER, 8'h00, 32'h8000_0000, 8'd0, 8'd0}, 1'b0, 3'd0, 36'd0}
    };

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_cfg_we      = 1'b0;
    logic [1:0]       i_cfg_addr    = CFG_BUS_MODE;
    logic [CFG_W-1:0] i_cfg_wdata   = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    // [7:0] byte_value, [39:8] number, [47:40] row, [55:48] column
    logic [55:0]      s_axis_tdata  = '0;
    // [2:0] operation
    logic [2:0]       s_axis_tuser  = OP_CHAR;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    // [0] register_select, [8:1] bus_value, [15:9] zero
    logic [15:0]      m_axis_tdata;
    logic             m_axis_tlast;

    // Shadow copy of the configuration, starting from the reset values.
    logic             four_bit_bus       = 1'b1;
    logic [CFG_W-1:0] enable_high_cycles = 26'd50000;
    logic [CFG_W-1:0] after_pulse_cycles = 26'd150000;
    logic [CFG_W-1:0] wakeup_cycles      = 26'd50000000;

    t_bus_xfer pending_xfers[$];
    int        mismatches   = 0;
    int        cycle_count  = 0;
    int        snd_idle_pct = 37;
    int        rcv_idle_pct = 55;

    char_lcd_write_sequencer_core #(.MAX_DIGITS(NUM_DIGITS)) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endfunction

    // Bus transfers that one request causes, appended to the pending queue.
    function automatic void predict_transfers(input t_request r);
        logic [8:0]  bytes_q[$];
        logic [3:0]  digits[$];
        logic [31:0] mag;
        logic [7:0]  column;
        logic        is_last;
        if (r.op == OP_CHAR) begin
            bytes_q.push_back({RS_DATA, r.byte_v});
        end else if (r.op == OP_COMMAND) begin
            bytes_q.push_back({RS_COMMAND, r.byte_v});
        end else if (r.op == OP_NUMBER) begin
            if (r.number == 32'd0) begin
                bytes_q.push_back({RS_DATA, ASCII_ZERO});
            end else begin
                mag = r.number;
                if (r.number[31]) begin
                    bytes_q.push_back({RS_DATA, ASCII_MINUS});
                    mag = ~r.number + 32'd1;
                end
                // Only the lowest digits survive if the store is too small.
                while (mag != 32'd0 && digits.size() < NUM_DIGITS) begin
                    digits.push_front(4'(mag % 32'd10));
                    mag = mag / 32'd10;
                end
                foreach (digits[i]) begin
                    bytes_q.push_back({RS_DATA, ASCII_ZERO + 8'(digits[i])});
                end
            end
        end else if (r.op == OP_GOTO) begin
            column = (r.column > MAX_COLUMN) ? 8'd0 : r.column;
            bytes_q.push_back({RS_COMMAND, ((r.row == 8'd1) ? ROW1_BASE : ROW0_BASE) + column});
        end else if (r.op == OP_INIT) begin
            if (four_bit_bus) begin
                foreach (INIT_FOUR[i]) bytes_q.push_back({RS_COMMAND, INIT_FOUR[i]});
            end else begin
                foreach (INIT_EIGHT[i]) bytes_q.push_back({RS_COMMAND, INIT_EIGHT[i]});
            end
        end
        foreach (bytes_q[i]) begin
            is_last = (i == bytes_q.size() - 1);
            if (four_bit_bus) begin
                pending_xfers.push_back(
                    t_bus_xfer'{bytes_q[i][8], {4'h0, bytes_q[i][7:4]}, 1'b0});
                pending_xfers.push_back(
                    t_bus_xfer'{bytes_q[i][8], {4'h0, bytes_q[i][3:0]}, is_last});
            end else begin
                pending_xfers.push_back(t_bus_xfer'{bytes_q[i][8], bytes_q[i][7:0], is_last});
            end
        end
    endfunction

    function automatic t_request random_request();
        t_request    r;
        int          pick;
        logic [31:0] decade;
        pick     = $urandom_range(0, 99);
        r.byte_v = 8'($urandom);
        r.number = $urandom;
        r.row    = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 1)) : 8'($urandom);
        r.column = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
        if (pick < 15) begin
            r.op = OP_CHAR;
        end else if (pick < 30) begin
            r.op = OP_COMMAND;
        end else if (pick < 58) begin
            r.op = OP_NUMBER;
        end else if (pick < 78) begin
            r.op = OP_GOTO;
        end else if (pick < 88) begin
            r.op = OP_INIT;
        end else begin
            r.op = 3'($urandom_range(OP_SPARE5, OP_SPARE7));
        end
        case ($urandom_range(0, 7))
            0: r.number = 32'd0;
            1: r.number = $urandom_range(1, 9);
            2: r.number = -$urandom_range(1, 99);
            3: r.number = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            4: begin
                // Either side of a power of ten, where the digit count changes.
                decade = 32'd1;
                repeat ($urandom_range(1, 9)) decade = decade * 32'd10;
                r.number = decade - 32'd1 + $urandom_range(0, 2);
                if ($urandom_range(0, 1) != 0) r.number = -r.number;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic offer_request(input t_request r);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r.column, r.row, r.number, r.byte_v};
        s_axis_tuser  <= r.op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Wait for every transfer to arrive, then for any ignored request to drain.
    task automatic settle_bus();
        s_axis_tvalid <= 1'b0;
        while (pending_xfers.size() != 0) @(posedge i_clk);
        repeat (int'(wakeup_cycles) + 2 * (int'(enable_high_cycles) + int'(after_pulse_cycles))
                + 32) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        case (idx)
            CFG_BUS_MODE:    four_bit_bus       = value[0];
            CFG_ENABLE_HIGH: enable_high_cycles = value;
            CFG_AFTER_PULSE: after_pulse_cycles = value;
            CFG_WAKEUP:      wakeup_cycles      = value;
            default: ;
        endcase
    endtask

    task automatic run_directed_rows();
        t_stim_row  s;
        logic [8:0] xf;
        int         k;
        foreach (DIRECTED_ROWS[i]) begin
            s = DIRECTED_ROWS[i];
            if (s.is_cfg) begin
                settle_bus();
                write_reg(s.req.op[1:0], s.req.number[CFG_W-1:0]);
                i_cfg_we <= 1'b0;
            end else begin
                if (s.typed) begin
                    for (k = 0; k < int'(s.n_typed); k++) begin
                        xf = s.typed_xfers[35 - 9 * k -: 9];
                        pending_xfers.push_back(
                            t_bus_xfer'{xf[8], xf[7:0], k == int'(s.n_typed) - 1});
                    end
                end else begin
                    predict_transfers(s.req);
                end
                offer_request(s.req);
            end
        end
    endtask

    task automatic run_random_phase(input int n_items, input int snd_pct, input int rcv_pct,
                                    input logic [CFG_W-1:0] mode_word,
                                    input logic [CFG_W-1:0] high_cycles,
                                    input logic [CFG_W-1:0] gap_cycles,
                                    input logic [CFG_W-1:0] wake_cycles);
        t_request r;
        int       done;
        settle_bus();
        write_reg(CFG_BUS_MODE, mode_word);
        write_reg(CFG_ENABLE_HIGH, high_cycles);
        write_reg(CFG_AFTER_PULSE, gap_cycles);
        write_reg(CFG_WAKEUP, wake_cycles);
        i_cfg_we <= 1'b0;
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        done = 0;
        while (done < n_items) begin
            r = random_request();
            predict_transfers(r);
            offer_request(r);
            // Ignored request codes do not count as items.
            if (r.op <= OP_INIT) done++;
        end
    endtask

    always @(posedge i_clk) begin
        t_bus_xfer want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_xfers.size() == 0) begin
                note_mismatch($sformatf("cycle %0d: unexpected transfer tdata=%04h last=%0b",
                                        cycle_count, m_axis_tdata, m_axis_tlast));
            end else begin
                want = pending_xfers.pop_front();
                if (m_axis_tdata != {7'd0, want.value, want.rs} || m_axis_tlast != want.last) begin
                    note_mismatch($sformatf(
                        "cycle %0d: expected rs=%0b value=%02h last=%0b, got tdata=%04h last=%0b",
                        cycle_count, want.rs, want.value, want.last, m_axis_tdata,
                        m_axis_tlast));
                end
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Shortest pacing straight after reset; the bus mode keeps its reset value.
        write_reg(CFG_ENABLE_HIGH, 26'd1);
        write_reg(CFG_AFTER_PULSE, 26'd1);
        write_reg(CFG_WAKEUP, 26'd0);
        i_cfg_we <= 1'b0;
        run_directed_rows();
        run_random_phase(26, 37, 55, {25'($urandom), 1'b1}, CFG_W'($urandom_range(1, 6)),
                         CFG_W'($urandom_range(1, 6)), CFG_W'($urandom_range(0, 40)));
        run_random_phase(26, 55, 37, {25'($urandom), 1'b0}, CFG_W'($urandom_range(2, 30)),
                         CFG_W'($urandom_range(2, 30)), CFG_W'($urandom_range(0, 100)));
        run_random_phase(26, 0, 0, {25'($urandom), 1'b1}, 26'd1, 26'd1, 26'd0);
        settle_bus();
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
